[sv/lgha_pkg.sv]
// Shared constants, types and FSM encoding for the logistic gradient/Hessian accumulator.
// No dependencies; every other file refers to it by scoped names.
package lgha_pkg;
	localparam int DIMENSIONS = 6;
	localparam int DIM_USED = (DIMENSIONS < 2) ? 2 : ((DIMENSIONS > 6) ? 6 : DIMENSIONS);
	localparam int NUM_BETA = 6;
	localparam int NUM_ENTRIES = DIM_USED + DIM_USED * (DIM_USED + 1) / 2;
	localparam int ADDR_W = $clog2(NUM_ENTRIES);
	localparam int DIM_W = $clog2(DIM_USED);
	localparam int IDX_W = 5;
	localparam int VAL_W = 64;
	localparam int FEAT_W = 24;
	localparam int MEAN_W = 18;
	localparam int CFG_IDX_W = 3;
	localparam int ZACC_W = 51;
	localparam int Z_W = ZACC_W - 16;
	localparam int NUM_W = 63;
	localparam int DEN_W = 44;
	localparam int QUO_W = 25;
	localparam int TERM_W = 42;

	localparam logic [CFG_IDX_W-1:0] REG_GENO_MEAN = 3'd6;
	localparam logic [1:0] GENO_MISSING = 2'b11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DOT,
		ST_SQA,
		ST_SQZ,
		ST_DIV,
		ST_WGT,
		ST_ACC,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  data;
	} ram_wr_t;
endpackage

[sv/lgha_sum_ram.sv]
// Sum store: one entry per gradient and Hessian sum, registered read, one write port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses lgha_pkg.
module lgha_sum_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lgha_pkg::ADDR_W-1:0] rd_addr,
	output logic [lgha_pkg::VAL_W-1:0]  rd_data,
	input  lgha_pkg::ram_wr_t           wr
);
	logic [lgha_pkg::VAL_W-1:0] mem [lgha_pkg::NUM_ENTRIES];
	logic [lgha_pkg::NUM_ENTRIES-1:0] vld_q;
	logic [lgha_pkg::VAL_W-1:0] rd_q;
	logic rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;
endmodule

[sv/lgha_div.sv]
// Restoring divider for the sigmoid, one quotient bit per cycle.
// Quotient is known to stay below 2^QUO_W. Uses lgha_pkg.
module lgha_div (
	input  logic               clk,
	input  logic               arst_n,
	input  lgha_pkg::div_req_t req,
	output lgha_pkg::div_rsp_t rsp
);
	localparam int SH_W = lgha_pkg::DEN_W + lgha_pkg::QUO_W - 1;
	localparam int CNT_W = $clog2(lgha_pkg::QUO_W);

	logic [lgha_pkg::NUM_W-1:0] rem_q;
	logic [SH_W-1:0] dsh_q;
	logic [lgha_pkg::QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [SH_W-1:0] rem_ext, diff;
	logic ge;

	assign rem_ext = {{(SH_W-lgha_pkg::NUM_W){1'b0}}, rem_q};
	assign ge = rem_ext >= dsh_q;
	assign diff = rem_ext - dsh_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= {req.den, {(lgha_pkg::QUO_W-1){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= diff[lgha_pkg::NUM_W-1:0];
			end
			quo_q <= {quo_q[lgha_pkg::QUO_W-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(lgha_pkg::QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule

[sv/logistic_grad_hessian_accumulator.sv]
// Top level: config registers, sample sequencer, shared multipliers, output register.
// Instantiates lgha_sum_ram and lgha_div; uses lgha_pkg.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | s_tdata sample word, s_tlast = last_sample
//  m_*     | out | m_tvalid/m_tready  | m_tdata sum word, m_tlast = last_entry
//  cfg_*   | in  | cfg_we             | cfg_index, cfg_data
//
// For six dimensions in the mid range a sample passes the accept cycle, D dot-product
// steps, two squaring steps, the bit-serial divider, the weight step, then one sum-store
// read-modify-write per entry (27 issues, after which the pipeline drains).
// The lower tail skips one squaring step; at or above three the divider is skipped.
// A last sample then emits each sum word via a read and a load state, stalling while m_tready is low.
// Samples are taken only in idle; the output register lets the next sample start while
// the final word waits. Reset clears the sums through valid bits, with no clearing pass.
module logistic_grad_hessian_accumulator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] genotype_code, [2] phenotype, [26:3] covariate_1, [50:27] covariate_2,
	// [74:51] covariate_3, [98:75] covariate_4, [122:99] covariate_5, rest zero
	input  logic [127:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [4:0] entry_index, [68:5] entry_value, rest zero
	output logic [71:0]  m_tdata,
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [lgha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgha_pkg::FEAT_W-1:0]    cfg_data
);
	localparam int D = lgha_pkg::DIM_USED;
	localparam int FW = lgha_pkg::FEAT_W;
	localparam int AW = lgha_pkg::ADDR_W;

	lgha_pkg::state_t state_q, state_d;

	logic signed [FW-1:0] beta_q [lgha_pkg::NUM_BETA];
	logic [lgha_pkg::MEAN_W-1:0] mean_q;
	logic signed [FW-1:0] f_q [D];
	logic signed [FW-1:0] fj_q;
	logic phen_q, last_q;

	logic signed [lgha_pkg::ZACC_W-1:0] zacc_q;
	logic [lgha_pkg::DIM_W-1:0] cnt_q, j_q, k_q;
	logic [39:0] sqa_q;
	logic [lgha_pkg::QUO_W-1:0] y_q;
	logic [22:0] w_q;
	logic signed [25:0] d_q;
	logic grad_q, iss_q;
	logic [AW-1:0] h_q, e_q;

	logic v_s1, g_s1, v_s2, g_s2;
	logic [AW-1:0] a_s1, a_s2;
	logic signed [57:0] m1_s1;
	logic signed [lgha_pkg::TERM_W-1:0] t_s2;
	logic signed [56:0] m2_s2;
	logic [lgha_pkg::VAL_W-1:0] rd_s2;

	logic out_valid_q, out_last_q;
	logic [lgha_pkg::IDX_W-1:0] out_idx_q;
	logic [lgha_pkg::VAL_W-1:0] out_val_q;

	logic signed [lgha_pkg::Z_W-1:0] z_w, negz;
	logic signed [19:0] z20, a20;
	logic ge3, le3;
	logic signed [31:0] ma;
	logic signed [25:0] mb;
	logic signed [57:0] pa;
	logic signed [lgha_pkg::TERM_W-1:0] r1, r2, t_sel;
	logic signed [56:0] pb;
	logic signed [64:0] sum65;
	logic [lgha_pkg::VAL_W-1:0] sum_sat;
	logic [lgha_pkg::DEN_W-1:0] den_t, den_m;
	logic [lgha_pkg::NUM_W-1:0] num_t, num_m;
	logic [39:0] zz;
	logic acc_end, emit_go, accept;
	logic [AW-1:0] rd_addr, iss_addr;
	logic [lgha_pkg::VAL_W-1:0] rd_data;

	lgha_pkg::div_req_t div_req;
	lgha_pkg::div_rsp_t div_rsp;
	lgha_pkg::ram_wr_t ram_wr;

	lgha_sum_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr      (ram_wr)
	);

	lgha_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sigmoid front end
	assign z_w = lgha_pkg::Z_W'((zacc_q + lgha_pkg::ZACC_W'(32768)) >>> 16);
	assign negz = -z_w;
	assign ge3 = z_w >= lgha_pkg::Z_W'(196608);
	assign le3 = z_w <= -lgha_pkg::Z_W'(196608);
	assign z20 = z_w[19:0];
	assign a20 = z20 + 20'sd196608;
	assign zz = pa[39:0];
	assign den_t = lgha_pkg::DEN_W'(65536) + (lgha_pkg::DEN_W'(negz) << 7);
	assign num_t = (lgha_pkg::NUM_W'(1) << 40) + lgha_pkg::NUM_W'(den_t >> 1);
	assign den_m = lgha_pkg::DEN_W'({zz, 1'b0}) + (lgha_pkg::DEN_W'(24) << 32);
	assign num_m = ((lgha_pkg::NUM_W'(sqa_q) + (lgha_pkg::NUM_W'(3) << 32)) << 24)
		+ lgha_pkg::NUM_W'(zz) + (lgha_pkg::NUM_W'(12) << 32);

	assign div_req.start = ((state_q == lgha_pkg::ST_SQA) && !ge3 && le3)
		|| (state_q == lgha_pkg::ST_SQZ);
	assign div_req.num = (state_q == lgha_pkg::ST_SQA) ? num_t : num_m;
	assign div_req.den = (state_q == lgha_pkg::ST_SQA) ? den_t : den_m;

	// shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			lgha_pkg::ST_DOT: begin
				ma = 32'(beta_q[cnt_q]);
				mb = 26'(f_q[cnt_q]);
			end
			lgha_pkg::ST_SQA: begin
				ma = 32'(a20);
				mb = 26'(a20);
			end
			lgha_pkg::ST_SQZ: begin
				ma = 32'(z20);
				mb = 26'(z20);
			end
			lgha_pkg::ST_WGT: begin
				ma = 32'($signed({1'b0, y_q}));
				mb = 26'sd16777216 - 26'($signed({1'b0, y_q}));
			end
			lgha_pkg::ST_ACC: begin
				if (grad_q) begin
					ma = 32'(d_q);
					mb = 26'(f_q[j_q]);
				end else begin
					ma = 32'(fj_q);
					mb = 26'(f_q[k_q]);
				end
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign pa = ma * mb;

	// accumulate pipeline arithmetic
	assign r1 = lgha_pkg::TERM_W'((m1_s1 + 58'sd32768) >>> 16);
	assign pb = $signed(r1[31:0]) * $signed({2'b00, w_q});
	assign r2 = lgha_pkg::TERM_W'((m2_s2 + 57'sd32768) >>> 16);
	assign t_sel = g_s2 ? t_s2 : r2;
	assign sum65 = $signed({rd_s2[lgha_pkg::VAL_W-1], rd_s2}) + 65'(t_sel);
	assign sum_sat = (sum65[64] != sum65[63]) ? {sum65[64], {(lgha_pkg::VAL_W-1){~sum65[64]}}}
		: sum65[63:0];

	assign iss_addr = grad_q ? AW'(j_q) : h_q;
	assign acc_end = !iss_q && !v_s1 && !v_s2;
	assign accept = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lgha_pkg::ST_IDLE: if (s_tvalid) state_d = lgha_pkg::ST_DOT;
			lgha_pkg::ST_DOT: if (cnt_q == lgha_pkg::DIM_W'(D - 1)) state_d = lgha_pkg::ST_SQA;
			lgha_pkg::ST_SQA: begin
				priority if (ge3) state_d = lgha_pkg::ST_WGT;
				else if (le3) state_d = lgha_pkg::ST_DIV;
				else state_d = lgha_pkg::ST_SQZ;
			end
			lgha_pkg::ST_SQZ: state_d = lgha_pkg::ST_DIV;
			lgha_pkg::ST_DIV: if (div_rsp.done) state_d = lgha_pkg::ST_WGT;
			lgha_pkg::ST_WGT: state_d = lgha_pkg::ST_ACC;
			lgha_pkg::ST_ACC: begin
				if (acc_end) state_d = last_q ? lgha_pkg::ST_EMIT_RD : lgha_pkg::ST_IDLE;
			end
			lgha_pkg::ST_EMIT_RD: state_d = lgha_pkg::ST_EMIT_LD;
			lgha_pkg::ST_EMIT_LD: begin
				if (emit_go) begin
					state_d = (e_q == AW'(lgha_pkg::NUM_ENTRIES - 1)) ? lgha_pkg::ST_IDLE
						: lgha_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = lgha_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready = 1'b0;
		emit_go = 1'b0;
		rd_addr = e_q;
		ram_wr.we = 1'b0;
		ram_wr.addr = a_s2;
		ram_wr.data = sum_sat;
		unique case (state_q)
			lgha_pkg::ST_IDLE: s_tready = 1'b1;
			lgha_pkg::ST_ACC: begin
				rd_addr = iss_addr;
				ram_wr.we = v_s2;
			end
			lgha_pkg::ST_EMIT_LD: begin
				emit_go = !out_valid_q || m_tready;
				ram_wr.we = emit_go;
				ram_wr.addr = e_q;
				ram_wr.data = '0;
			end
			default: s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgha_pkg::ST_IDLE;
			for (int i = 0; i < lgha_pkg::NUM_BETA; i++) beta_q[i] <= '0;
			mean_q <= '0;
			cnt_q <= '0;
			j_q <= '0;
			k_q <= '0;
			h_q <= '0;
			e_q <= '0;
			grad_q <= 1'b0;
			iss_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index < lgha_pkg::CFG_IDX_W'(lgha_pkg::NUM_BETA)) begin
					beta_q[cfg_index] <= cfg_data;
				end else if (cfg_index == lgha_pkg::REG_GENO_MEAN) begin
					mean_q <= cfg_data[lgha_pkg::MEAN_W-1:0];
				end
			end
			if (accept) cnt_q <= '0;
			else if (state_q == lgha_pkg::ST_DOT) cnt_q <= cnt_q + 1'b1;

			v_s1 <= (state_q == lgha_pkg::ST_ACC) && iss_q;
			v_s2 <= v_s1;
			if (state_q == lgha_pkg::ST_WGT) begin
				j_q <= '0;
				k_q <= '0;
				grad_q <= 1'b1;
				iss_q <= 1'b1;
				h_q <= AW'(D);
			end else if ((state_q == lgha_pkg::ST_ACC) && iss_q) begin
				if (grad_q) begin
					grad_q <= 1'b0;
					k_q <= '0;
				end else begin
					h_q <= h_q + 1'b1;
					if (k_q == j_q) begin
						if (j_q == lgha_pkg::DIM_W'(D - 1)) iss_q <= 1'b0;
						else begin
							j_q <= j_q + 1'b1;
							grad_q <= 1'b1;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
			end

			if (emit_go) begin
				e_q <= (e_q == AW'(lgha_pkg::NUM_ENTRIES - 1)) ? '0 : e_q + 1'b1;
			end
			if (emit_go) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			f_q[0] <= (s_tdata[1:0] == lgha_pkg::GENO_MISSING) ? FW'(mean_q)
				: FW'({s_tdata[1:0], 16'h0000});
			for (int j = 1; j < D; j++) f_q[j] <= s_tdata[3 + (j - 1) * FW +: FW];
			phen_q <= s_tdata[2];
			last_q <= s_tlast;
			zacc_q <= '0;
		end else if (state_q == lgha_pkg::ST_DOT) begin
			zacc_q <= zacc_q + lgha_pkg::ZACC_W'(pa);
		end
		if (state_q == lgha_pkg::ST_SQA) begin
			sqa_q <= pa[39:0];
			if (ge3) y_q <= lgha_pkg::QUO_W'(1) << 24;
		end
		if ((state_q == lgha_pkg::ST_DIV) && div_rsp.done) y_q <= div_rsp.quo;
		if (state_q == lgha_pkg::ST_WGT) begin
			w_q <= 23'((pa + 58'sd8388608) >>> 24);
			d_q <= phen_q ? (26'sd16777216 - $signed({1'b0, y_q}))
				: -$signed({1'b0, y_q});
		end
		if ((state_q == lgha_pkg::ST_ACC) && grad_q) fj_q <= f_q[j_q];
		m1_s1 <= pa;
		g_s1 <= grad_q;
		a_s1 <= iss_addr;
		m2_s2 <= pb;
		t_s2 <= r1;
		g_s2 <= g_s1;
		a_s2 <= a_s1;
		rd_s2 <= rd_data;
		if (emit_go) begin
			out_idx_q <= lgha_pkg::IDX_W'(e_q);
			out_val_q <= rd_data;
			out_last_q <= (e_q == AW'(lgha_pkg::NUM_ENTRIES - 1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {3'b000, out_val_q, out_idx_q};
	assign m_tlast = out_last_q;

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == lgha_pkg::ST_DIV))
		else $error("divider finished outside the divide state");

	a_rmw_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lgha_pkg::ST_ACC && iss_q && ram_wr.we) |-> (ram_wr.addr != rd_addr))
		else $error("sum store read and write hit one entry");

	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |-> (!out_valid_q || m_tready))
		else $error("output word overwritten");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && e_q == AW'(lgha_pkg::NUM_ENTRIES - 1)) |=> (state_q == lgha_pkg::ST_IDLE))
		else $error("emission did not end after the final entry");
endmodule

[tb/logistic_grad_hessian_accumulator_tb.sv]
// Self-checking bench for logistic_grad_hessian_accumulator: drives sample words on s_*,
// predicts gradient/Hessian sums per run and checks every m_* word in order.
// Depends on lgha_pkg and the DUT sources.
module logistic_grad_hessian_accumulator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NDIM = lgha_pkg::DIM_USED;
	localparam int NTRI = NDIM * (NDIM + 1) / 2;
	localparam logic [lgha_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic [1:0] GENO_TWO = 2'd2;
	localparam logic signed [lgha_pkg::FEAT_W-1:0] FEAT_MAX = 24'sh7FFFFF;
	localparam logic signed [lgha_pkg::FEAT_W-1:0] FEAT_MIN = -24'sh800000;
	localparam logic signed [lgha_pkg::FEAT_W-1:0] FEAT_ONE = 24'sh010000;
	localparam longint SUM_MAX = 64'sh7FFFFFFFFFFFFFFF;
	localparam longint SUM_MIN = -64'sh7FFFFFFFFFFFFFFF - 1;

	typedef struct {
		logic [1:0]              geno;
		logic                    pheno;
		logic signed [lgha_pkg::FEAT_W-1:0] cov [5];
		logic                    last;
	} sample_t;

	typedef struct {
		logic [lgha_pkg::IDX_W-1:0] idx;
		longint           val;
		logic             last;
	} entry_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tlast = 0;
	logic [127:0] s_tdata = '0;
	logic m_tvalid, m_tready = 0, m_tlast;
	logic [71:0] m_tdata;
	logic cfg_we = 0;
	logic [lgha_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lgha_pkg::FEAT_W-1:0] cfg_data = '0;

	logistic_grad_hessian_accumulator i_dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// predictor state
	longint beta [lgha_pkg::NUM_BETA];
	longint geno_mean;
	longint grad_sum [NDIM];
	longint hess_sum [NTRI];
	entry_t pending_entries [$];
	int errors = 0, words_seen = 0, runs_sent = 0, samples_sent = 0;

	function automatic longint rnd_shr(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint add_sat(longint a, longint b);
		longint r;
		r = a + b;
		if (b > 0 && r < a) return SUM_MAX;
		if (b < 0 && r > a) return SUM_MIN;
		return r;
	endfunction

	function automatic longint sigmoid_q24(longint z);
		longint three, a, num, den;
		three = 3 * 65536;
		if (z >= three) return longint'(1) << 24;
		if (z <= -three) begin
			den = 65536 + 128 * (-z);
			num = longint'(1) << 40;
			return (num + den / 2) / den;
		end
		a = z + three;
		num = a * a + 3 * (longint'(1) << 32);
		den = 2 * z * z + 24 * (longint'(1) << 32);
		return ((num << 24) + den / 2) / den;
	endfunction

	task automatic predict_sample(sample_t smp);
		longint f [6];
		longint z, y, w, d, p;
		entry_t e;
		int h;
		f[0] = (smp.geno == lgha_pkg::GENO_MISSING) ? geno_mean
			: longint'(smp.geno) * 65536;
		for (int j = 1; j < 6; j++) f[j] = longint'(smp.cov[j-1]);
		z = 0;
		for (int j = 0; j < NDIM; j++) z += beta[j] * f[j];
		z = rnd_shr(z, 16);
		y = sigmoid_q24(z);
		w = rnd_shr(y * ((longint'(1) << 24) - y), 24);
		d = (smp.pheno ? (longint'(1) << 24) : 0) - y;
		h = 0;
		for (int j = 0; j < NDIM; j++) begin
			grad_sum[j] = add_sat(grad_sum[j], rnd_shr(d * f[j], 16));
			for (int k = 0; k <= j; k++) begin
				p = rnd_shr(f[j] * f[k], 16);
				hess_sum[h] = add_sat(hess_sum[h], rnd_shr(p * w, 16));
				h++;
			end
		end
		if (!smp.last) return;
		for (int j = 0; j < NDIM + NTRI; j++) begin
			e.idx = j[lgha_pkg::IDX_W-1:0];
			e.val = (j < NDIM) ? grad_sum[j] : hess_sum[j - NDIM];
			e.last = (j == NDIM + NTRI - 1);
			pending_entries.push_back(e);
		end
		foreach (grad_sum[j]) grad_sum[j] = 0;
		foreach (hess_sum[j]) hess_sum[j] = 0;
	endtask

	task automatic write_reg(logic [lgha_pkg::CFG_IDX_W-1:0] idx,
		logic [lgha_pkg::FEAT_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx < lgha_pkg::NUM_BETA) beta[idx] = longint'($signed(val));
		else if (idx == lgha_pkg::REG_GENO_MEAN) geno_mean = longint'(val[lgha_pkg::MEAN_W-1:0]);
	endtask

	// drop valid after the final word of a burst, then wait for every sum word
	task automatic wait_drained();
		s_tvalid <= 0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	int burst_left = 0;

	task automatic send_sample(sample_t smp);
		logic [127:0] dat;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		dat = '0;
		dat[1:0] = smp.geno;
		dat[2] = smp.pheno;
		for (int j = 0; j < 5; j++) dat[3 + 24*j +: 24] = smp.cov[j];
		s_tvalid <= 1;
		s_tdata <= dat;
		s_tlast <= smp.last;
		predict_sample(smp);
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		if (smp.last) runs_sent++;
	endtask

	function automatic logic signed [lgha_pkg::FEAT_W-1:0] rand_feat();
		unique case ($urandom_range(0, 5))
			0: return FEAT_MAX;
			1: return FEAT_MIN;
			2: return FEAT_ONE;
			3: return $signed(24'($urandom_range(0, 24'h03FFFF))) - 24'sh020000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic sample_t rand_sample(logic last);
		sample_t smp;
		smp.geno = 2'($urandom);
		smp.pheno = 1'($urandom);
		foreach (smp.cov[j]) smp.cov[j] = rand_feat();
		smp.last = last;
		return smp;
	endfunction

	// receiver: stall pattern with quiet stretches
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
		unique case (stall_mode)
			0: m_tready <= 1;
			1: m_tready <= $urandom_range(0, 3) != 0;
			default: m_tready <= $urandom_range(0, 3) == 0;
		endcase
	end

	always @(posedge clk) begin
		entry_t e;
		logic [lgha_pkg::IDX_W-1:0] idx;
		longint val;
		if (arst_n && m_tvalid && m_tready) begin
			idx = m_tdata[4:0];
			val = m_tdata[68:5];
			words_seen++;
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected word idx=%0d val=%0d", $time, idx, val);
				errors++;
			end else begin
				e = pending_entries.pop_front();
				if (idx !== e.idx || val !== e.val || m_tlast !== e.last) begin
					$display("%0t: mismatch exp idx=%0d val=%0d last=%0b got idx=%0d val=%0d last=%0b",
						$time, e.idx, e.val, e.last, idx, val, m_tlast);
					errors++;
				end
			end
		end
	end

	// directed rows: config setting then sample
	typedef struct {
		logic [1:0] geno;
		logic       pheno;
		logic signed [lgha_pkg::FEAT_W-1:0] cv;
		logic       last;
	} row_t;

	initial begin
		row_t rows [6];
		sample_t smp;
		foreach (beta[j]) beta[j] = 0;
		geno_mean = 0;
		foreach (grad_sum[j]) grad_sum[j] = 0;
		foreach (hess_sum[j]) hess_sum[j] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// betas zero: y = 1/2 exactly; one zero sample gives all-zero sums
		smp.geno = 0; smp.pheno = 0; smp.last = 1;
		foreach (smp.cov[j]) smp.cov[j] = 0;
		send_sample(smp);
		wait_drained();

		// extremes, missing genotype, tails of the sigmoid
		rows = '{
			'{2'd0, 1'b0, 24'sh0, 1'b0}, '{2'd1, 1'b1, FEAT_ONE, 1'b0},
			'{GENO_TWO, 1'b0, FEAT_MAX, 1'b0},
			'{lgha_pkg::GENO_MISSING, 1'b1, FEAT_MIN, 1'b1},
			'{lgha_pkg::GENO_MISSING, 1'b0, FEAT_MAX, 1'b0}, '{2'd1, 1'b1, FEAT_MIN, 1'b1}};
		for (int cfg = 0; cfg < 3; cfg++) begin
			unique case (cfg)
				0: begin
					for (int j = 0; j < lgha_pkg::NUM_BETA; j++)
						write_reg(lgha_pkg::CFG_IDX_W'(j), 24'h010000);
					write_reg(lgha_pkg::REG_GENO_MEAN, 24'h020000);
				end
				1: begin
					for (int j = 0; j < lgha_pkg::NUM_BETA; j++)
						write_reg(lgha_pkg::CFG_IDX_W'(j), FEAT_MAX);
					write_reg(lgha_pkg::REG_GENO_MEAN, 24'h03FFFF);
				end
				default: begin
					for (int j = 0; j < lgha_pkg::NUM_BETA; j++)
						write_reg(lgha_pkg::CFG_IDX_W'(j), FEAT_MIN);
					write_reg(lgha_pkg::REG_GENO_MEAN, 24'h0);
				end
			endcase
			foreach (rows[r]) begin
				smp.geno = rows[r].geno; smp.pheno = rows[r].pheno; smp.last = rows[r].last;
				foreach (smp.cov[j]) smp.cov[j] = (j % 2) ? -rows[r].cv : rows[r].cv;
				send_sample(smp);
			end
			wait_drained();
		end
		// index past the register file is ignored
		write_reg(REG_UNUSED, 24'h123456);

		// random runs, short ones mostly, new setting between phases
		for (int ph = 0; ph < 8; ph++) begin
			for (int j = 0; j < lgha_pkg::NUM_BETA; j++)
				write_reg(lgha_pkg::CFG_IDX_W'(j), ($urandom_range(0, 3) == 0) ? 24'($urandom)
					: 24'($signed($urandom_range(0, 24'h01FFFF)) - 24'sh010000));
			write_reg(lgha_pkg::REG_GENO_MEAN, 24'($urandom_range(0, 18'h3FFFF)));
			for (int n = 0; n < 50; n++) send_sample(rand_sample($urandom_range(0, 5) == 0));
			smp = rand_sample(1);
			send_sample(smp);
			wait_drained();
		end

		$display("Sent %0d samples in %0d runs; checked %0d sum words.",
			samples_sent, runs_sent, words_seen);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end
endmodule
